@@ src/tcw_pkg.sv @@
// Package for the text console character writer.
// Types, screen geometry and character codes shared by every module.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = ROWS * COLS;
    localparam int COL_W    = $clog2(COLS);
    localparam int ROW_W    = $clog2(ROWS + 1);   // row may reach ROWS before a scroll
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int PROD_W   = ADDR_W + ROW_W;
    localparam int CURSOR_W = 11;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [COL_W:0] TAB_MASK = ~(COL_W + 1)'(3);

    typedef enum logic [2:0] {
        K_CR,
        K_LF,
        K_TAB,
        K_BS,
        K_CHAR,
        K_READ,
        K_CLEAR,
        K_NOP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        ch;
        logic              last;
        logic              rd_ok;
        logic [ADDR_W-1:0] rd_addr;
    } cmd_t;

    typedef struct packed {
        logic                scrolled;
        logic [CURSOR_W-1:0] cursor_pos;
        logic [7:0]          cell_attr;
        logic [7:0]          cell_char;
    } result_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_TAB,
        S_CLEAR,
        S_SCROLL,
        S_BLANK,
        S_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        logic [PROD_W-1:0] p;
        p = PROD_W'(r) * PROD_W'(COLS) + PROD_W'(c);
        return p[ADDR_W-1:0];
    endfunction

    function automatic logic is_put(input kind_t k);
        return (k == K_CR) || (k == K_LF) || (k == K_TAB) || (k == K_BS) ||
               (k == K_CHAR);
    endfunction

endpackage

`default_nettype wire

@@ src/tcw_front.sv @@
// Front end: accepts input items and classifies them into queue commands.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front (
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,   // char_code, read_row, read_col, zero pad
    input  wire logic         s_tlast,   // last_of_write
    input  wire logic [1:0]   s_tuser,   // cmd
    output logic              push_valid,
    input  wire logic         push_ready,
    output tcw_pkg::cmd_t     push_data
);
    import tcw_pkg::*;

    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
    logic       in_range;

    assign char_code = s_tdata[7:0];
    assign read_row  = s_tdata[12:8];
    assign read_col  = s_tdata[19:13];

    assign in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLS);

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb begin
        push_data.ch      = char_code;
        push_data.last    = s_tlast;
        push_data.rd_ok   = in_range;
        push_data.rd_addr = cell_addr(ROW_W'(read_row), COL_W'(read_col));
        unique case (s_tuser)
            CMD_PUT: begin
                unique case (char_code)
                    CH_CR:   push_data.kind = K_CR;
                    CH_LF:   push_data.kind = K_LF;
                    CH_TAB:  push_data.kind = K_TAB;
                    CH_BS:   push_data.kind = K_BS;
                    default: push_data.kind = K_CHAR;
                endcase
            end
            CMD_READ:  push_data.kind = K_READ;
            CMD_CLEAR: push_data.kind = K_CLEAR;
            default:   push_data.kind = K_NOP;
        endcase
    end

endmodule

`default_nettype wire

@@ src/tcw_queue.sv @@
// Short command queue between front and back end.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire tcw_pkg::cmd_t push_data,
    output logic               pop_valid,
    input  wire logic          pop,
    output tcw_pkg::cmd_t      pop_data
);
    import tcw_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != (QPTR_W + 1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ src/tcw_back.sv @@
// Back end: owns the character store, cursor and attribute register,
// carries out queued commands and holds the result register. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    input  wire logic          q_valid,
    input  wire tcw_pkg::cmd_t q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output tcw_pkg::result_t   m_result
);
    import tcw_pkg::*;

    logic [15:0] mem [CELLS];
    logic [15:0] rd_data_reg;
    logic        we, re;
    logic [ADDR_W-1:0] wa, ra;
    logic [15:0] wd;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [CURSOR_W-1:0] hw_reg, hw_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [COL_W:0]      stop_reg, stop_next;
    cmd_t                item_reg, item_next;
    logic                scrolled_reg, scrolled_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [7:0]          attr_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic           slot_free;
    logic [COL_W:0] col_inc;
    logic [15:0]    blank;

    assign slot_free = !out_valid_reg || m_tready;
    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign blank     = {attr_reg, CH_SPACE};
    assign m_tvalid  = out_valid_reg;
    assign m_result  = out_reg;

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        hw_next        = hw_reg;
        cnt_next       = cnt_reg;
        stop_next      = stop_reg;
        item_next      = item_reg;
        scrolled_next  = scrolled_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        we             = 1'b0;
        wa             = cell_addr(row_reg, col_reg);
        wd             = blank;
        re             = 1'b0;
        ra             = q_data.rd_addr;

        unique case (state_reg)
            S_INIT: begin
                // post-reset pass: every cell to a space in the reset attribute
                we = 1'b1;
                wa = cnt_reg;
                wd = {ATTR_RESET, CH_SPACE};
                if (cnt_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    item_next     = q_data;
                    scrolled_next = 1'b0;
                    state_next    = S_DONE;
                    unique case (q_data.kind)
                        K_CR: col_next = '0;
                        K_LF: begin
                            col_next = '0;
                            row_next = row_reg + 1'b1;
                        end
                        K_TAB: begin
                            stop_next  = ({1'b0, col_reg} + (COL_W + 1)'(4)) & TAB_MASK;
                            state_next = S_TAB;
                        end
                        K_BS: begin
                            if (col_reg != '0) begin
                                col_next = col_reg - 1'b1;
                                we       = 1'b1;
                                wa       = cell_addr(row_reg, col_reg - 1'b1);
                            end
                        end
                        K_CHAR: begin
                            we = 1'b1;
                            wd = {attr_reg, q_data.ch};
                            if (col_inc == (COL_W + 1)'(COLS)) begin
                                col_next = '0;
                                row_next = row_reg + 1'b1;
                            end else begin
                                col_next = col_inc[COL_W-1:0];
                            end
                        end
                        K_READ: re = q_data.rd_ok;
                        K_CLEAR: begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_TAB: begin
                we = 1'b1;
                if (col_inc == (COL_W + 1)'(COLS)) begin
                    col_next   = '0;
                    row_next   = row_reg + 1'b1;
                    state_next = S_DONE;
                end else begin
                    col_next = col_inc[COL_W-1:0];
                    if (col_inc == stop_reg) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_CLEAR: begin
                we = 1'b1;
                wa = cnt_reg;
                if (cnt_reg == ADDR_W'(CELLS - 1)) begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SCROLL: begin
                // read one row down, write the cell read in the cycle before
                re             = 1'b1;
                ra             = cnt_reg + ADDR_W'(COLS);
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
                if (pend_reg) begin
                    we = 1'b1;
                    wa = pend_addr_reg;
                    wd = rd_data_reg;
                end
                if (cnt_reg == ADDR_W'(CELLS - COLS - 1)) begin
                    state_next = S_BLANK;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            S_BLANK: begin
                we = 1'b1;
                if (pend_reg) begin
                    wa = pend_addr_reg;
                    wd = rd_data_reg;
                end else begin
                    wa = cnt_reg;
                    if (cnt_reg == ADDR_W'(CELLS - 1)) begin
                        row_next      = ROW_W'(ROWS - 1);
                        scrolled_next = 1'b1;
                        state_next    = S_DONE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (row_reg == ROW_W'(ROWS)) begin
                    cnt_next   = '0;
                    state_next = S_SCROLL;
                end else if (slot_free) begin
                    if (item_reg.kind == K_CLEAR) begin
                        hw_next = '0;
                    end else if (is_put(item_reg.kind) && item_reg.last) begin
                        hw_next = CURSOR_W'(cell_addr(row_reg, col_reg));
                    end
                    if (item_reg.kind == K_READ && item_reg.rd_ok) begin
                        out_next.cell_char = rd_data_reg[7:0];
                        out_next.cell_attr = rd_data_reg[15:8];
                    end else begin
                        out_next.cell_char = '0;
                        out_next.cell_attr = '0;
                    end
                    out_next.cursor_pos = hw_next;
                    out_next.scrolled   = scrolled_reg;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            hw_reg        <= '0;
            cnt_reg       <= '0;
            scrolled_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            hw_reg        <= hw_next;
            cnt_reg       <= cnt_next;
            scrolled_reg  <= scrolled_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stop_reg      <= stop_next;
        item_reg      <= item_next;
        pend_addr_reg <= pend_addr_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem[ra];
        end
    end

`ifndef SYNTHESIS
    a_no_pop_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INIT) |-> !q_pop)
        else $error("command taken during store initialisation");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(col_reg) < COLS)
        else $error("cursor column out of range");

    a_row_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (32'(row_reg) < ROWS))
        else $error("cursor row past bottom while idle");

    a_pend_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (state_reg == S_SCROLL || state_reg == S_BLANK))
        else $error("pending scroll write outside scroll");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && state_next == S_IDLE) |=> out_valid_reg)
        else $error("finished item left no result");
`endif

endmodule

`default_nettype wire

@@ src/text_console_character_writer.sv @@
// Text console character writer: 80x25 character store with cursor.
// Front end, command queue and back end. Depends on tcw_pkg, tcw_front,
// tcw_queue and tcw_back.
//
// Input stream s_*: tuser = command (put character, read cell, clear screen),
// tlast = last character of a write (loads the hardware cursor), tdata =
// character byte and cell row/column for reads. One result item per input
// item on m_*: cell character and attribute (zero unless a read), hardware
// cursor position, and a flag that the item scrolled the screen.
// cfg_wr_en/cfg_wr_data load the attribute used for written and blanked cells.
//
// In the back end a tab writes spaces up to the next tab stop or the line end,
// and a clear blanks every cell; a scroll checks the row, copies each cell one
// row up, drains the last pending write and blanks the bottom row. The store
// has a single write port, so these steps go through their cells one by one.
// After reset the store is filled with spaces (attribute 07); no item is
// taken meanwhile, but the two-entry queue fills.
// A stalled receiver holds the result register; the back end stops at its
// result step and the queue then backs up onto s_tready.
`timescale 1ns / 1ps
`default_nettype none

module text_console_character_writer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code, read_row, read_col, zero pad
    input  wire logic        s_tlast,   // last_of_write
    input  wire logic [1:0]  s_tuser,   // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // cell_char, cell_attr, cursor_pos, scrolled, zero pad
);
    import tcw_pkg::*;

    cmd_t    push_data, pop_data;
    logic    push_valid, push_ready, pop_valid, pop;
    result_t result;

    tcw_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    tcw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (pop_valid),
        .q_data      (pop_data),
        .q_pop       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (result)
    );

    assign m_tdata = {(32 - $bits(result_t))'(0), result};

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking bench for text_console_character_writer: streams console commands,
// predicts every reply with its own screen model and compares field by field.
// Depends on tcw_pkg and the RTL of the console writer.
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int TAIL_CYCLES = 64;
    localparam int LONG_HOLD   = 300;
    localparam int PRINT_CAP   = 50;

    typedef struct {
        logic [1:0] op;
        logic [7:0] code;
        logic       ends_write;
        logic [4:0] row;
        logic [6:0] col;
    } console_item_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'h00;
    logic        s_tvalid    = 1'b0;
    logic [23:0] s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic [1:0]  s_tuser     = CMD_PUT;
    logic        m_tready    = 1'b1;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    text_console_character_writer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    // screen model
    logic [15:0] screen_model [CELLS];
    int unsigned cur_col, cur_row, hw_pos;
    logic [7:0]  attr_now;

    result_t     console_replies [$];
    int unsigned items_sent, replies_seen, mismatches, input_stalls, cycle_count;
    int unsigned reads_done, scrolls_done, clears_done;
    bit          idle_on;
    int          hold_request, hold_left, stall_left;

    function automatic void reset_console_model();
        for (int i = 0; i < CELLS; i++) screen_model[i] = {ATTR_RESET, CH_SPACE};
        cur_col  = 0;
        cur_row  = 0;
        hw_pos   = 0;
        attr_now = ATTR_RESET;
    endfunction

    function automatic void put_cell(input logic [7:0] ch);
        screen_model[cur_row * COLS + cur_col] = {attr_now, ch};
    endfunction

    function automatic result_t console_apply(input console_item_t it);
        result_t     r;
        int unsigned stop;
        logic [15:0] cell_word;
        r = '0;
        case (it.op)
            CMD_PUT: begin
                case (it.code)
                    CH_CR: cur_col = 0;
                    CH_LF: begin
                        cur_col = 0;
                        cur_row++;
                    end
                    CH_TAB: begin
                        stop = (cur_col + 4) & ~32'd3;
                        while (cur_col < stop && cur_col < COLS) begin
                            put_cell(CH_SPACE);
                            cur_col++;
                        end
                        if (cur_col >= COLS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                    CH_BS: begin
                        if (cur_col > 0) begin
                            cur_col--;
                            put_cell(CH_SPACE);
                        end
                    end
                    default: begin
                        put_cell(it.code);
                        cur_col++;
                        if (cur_col >= COLS) begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                endcase
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLS; i++)
                        screen_model[i] = screen_model[i + COLS];
                    for (int i = 0; i < COLS; i++)
                        screen_model[(ROWS - 1) * COLS + i] = {attr_now, CH_SPACE};
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                    scrolls_done++;
                end
                if (it.ends_write) hw_pos = cur_row * COLS + cur_col;
            end
            CMD_READ: begin
                reads_done++;
                if (it.row < ROWS && it.col < COLS) begin
                    cell_word = screen_model[it.row * COLS + it.col];
                    r.cell_char = cell_word[7:0];
                    r.cell_attr = cell_word[15:8];
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen_model[i] = {attr_now, CH_SPACE};
                cur_col = 0;
                cur_row = 0;
                hw_pos  = 0;
                clears_done++;
            end
            default: ;
        endcase
        r.cursor_pos = CURSOR_W'(hw_pos);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got_v,
                                   input int unsigned want_v);
        if (mismatches < PRINT_CAP)
            $display("reply %0d: %s is 0x%0h, predicted 0x%0h", replies_seen, what, got_v, want_v);
        mismatches++;
    endtask

    always @(posedge aclk) begin : reply_check
        result_t got, want;
        if (aresetn && s_tvalid && s_tready === 1'b0) input_stalls++;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata[27:0];
            if (console_replies.size() == 0) begin
                report_mismatch("reply with none pending", 32'(got), 0);
            end else begin
                want = console_replies.pop_front();
                if (got.cell_char !== want.cell_char)
                    report_mismatch("cell_char", 32'(got.cell_char), 32'(want.cell_char));
                if (got.cell_attr !== want.cell_attr)
                    report_mismatch("cell_attr", 32'(got.cell_attr), 32'(want.cell_attr));
                if (got.cursor_pos !== want.cursor_pos)
                    report_mismatch("cursor_pos", 32'(got.cursor_pos), 32'(want.cursor_pos));
                if (got.scrolled !== want.scrolled)
                    report_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
            end
            replies_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d replies pending",
                     cycle_count, console_replies.size());
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: long hold-off on request, otherwise random stall bursts while idle_on is set
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge; returns at the falling edge after the handshake
    task automatic send_item(input console_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tlast  <= it.ends_write;
        s_tdata  <= {4'b0, it.col, it.row, it.code};
        do @(posedge aclk); while (s_tready !== 1'b1);
        console_replies.push_back(console_apply(it));
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic console_item_t fresh_item(input logic [1:0] op);
        console_item_t it;
        it.op         = op;
        it.code       = 8'($urandom);
        it.ends_write = 1'($urandom);
        it.row        = 5'($urandom);
        it.col        = 7'($urandom);
        return it;
    endfunction

    task automatic send_put(input logic [7:0] code, input logic fin);
        console_item_t it;
        it            = fresh_item(CMD_PUT);
        it.code       = code;
        it.ends_write = fin;
        send_item(it);
    endtask

    task automatic send_read(input int unsigned r, input int unsigned c);
        console_item_t it;
        it     = fresh_item(CMD_READ);
        it.row = 5'(r);
        it.col = 7'(c);
        send_item(it);
    endtask

    task automatic drain_console_replies();
        s_tvalid <= 1'b0;
        while (console_replies.size() != 0) @(negedge aclk);
    endtask

    task automatic set_attr(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        attr_now     = value;
    endtask

    function automatic logic [7:0] text_byte();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 58) return 8'($urandom_range(8'h20, 8'h7E));
        if (p < 68) return 8'($urandom);
        if (p < 82) return CH_LF;
        if (p < 88) return CH_TAB;
        if (p < 94) return CH_BS;
        return CH_CR;
    endfunction

    task automatic test_power_on_state();
        send_read(0, 0);
        send_read(ROWS - 1, COLS - 1);
        send_read(ROWS, 0);
        send_read(0, COLS);
        send_read(31, 127);
        send_item(fresh_item(CMD_UNUSED));
    endtask

    task automatic test_control_codes();
        send_put(8'h00, 1'b0);
        send_put(8'hFF, 1'b1);
        send_put(CH_BS, 1'b0);
        send_read(0, 1);
        send_put(CH_CR, 1'b0);
        send_put(CH_BS, 1'b1);        // column zero: no effect
        send_put(8'h41, 1'b0);
        send_put(CH_TAB, 1'b1);
        send_read(0, 3);
        send_put(CH_LF, 1'b1);
        send_read(0, 0);
        send_item(fresh_item(CMD_CLEAR));
        send_read(0, 0);
        send_put(8'h7E, 1'b1);
    endtask

    task automatic run_console_traffic(input int unsigned n, input bit allow_idle);
        int unsigned target, pick, len, k, r;
        target = items_sent + n;
        while (items_sent < target) begin
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            pick    = $urandom_range(0, 99);
            if (pick < 52) begin
                len = $urandom_range(1, 24);
                for (k = 0; k < len; k++)
                    send_put(text_byte(), k == len - 1 || $urandom_range(0, 15) == 0);
            end else if (pick < 62) begin
                // long line of 70 to 90 characters, which can wrap
                len = $urandom_range(70, 90);
                for (k = 0; k < len; k++)
                    send_put(8'($urandom_range(8'h21, 8'h7E)), k == len - 1);
            end else if (pick < 70) begin
                // run of tabs from a random column, which may cross the line end
                len = $urandom_range(0, 3);
                for (k = 0; k < len; k++) send_put(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
                len = $urandom_range(15, 21);
                for (k = 0; k < len; k++) send_put(CH_TAB, k == len - 1);
            end else if (pick < 93) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(0, 9);
                    if (r < 5)      send_read(cur_row, $urandom_range(0, COLS - 1));
                    else if (r < 9) send_read($urandom_range(0, ROWS - 1),
                                              $urandom_range(0, COLS - 1));
                    else            send_read($urandom_range(0, 31), $urandom_range(0, 127));
                end
            end else if (pick < 97) begin
                send_item(fresh_item(CMD_UNUSED));
            end else begin
                send_item(fresh_item(CMD_CLEAR));
            end
        end
    endtask

    task automatic test_sender_pause();
        run_console_traffic(60, 1'b1);
        drain_console_replies();
        run_console_traffic(60, 1'b1);
    endtask

    task automatic test_output_backpressure();
        int k;
        idle_on = 1'b0;
        @(posedge aclk);
        hold_request = LONG_HOLD;
        @(negedge aclk);
        for (k = 0; k < 20; k++) send_put(text_byte(), k == 19);
        send_read(cur_row, 0);
    endtask

    initial begin
        reset_console_model();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        idle_on = 1'b1;
        test_power_on_state();
        drain_console_replies();

        set_attr(8'h00);
        test_control_codes();
        drain_console_replies();

        set_attr(8'hFF);
        test_sender_pause();
        drain_console_replies();

        set_attr(8'($urandom));
        test_output_backpressure();
        drain_console_replies();

        set_attr(8'($urandom));
        run_console_traffic(230, 1'b1);
        drain_console_replies();

        // closing stretch without idling
        set_attr(8'($urandom));
        idle_on = 1'b0;
        run_console_traffic(150, 1'b0);
        drain_console_replies();
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("%0d items, %0d replies: %0d reads, %0d scrolls, %0d clears",
                 items_sent, replies_seen, reads_done, scrolls_done, clears_done);
        $display("attributes 07, 00, FF and random; %0d input stall cycles, %0d mismatches",
                 input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_character_writer.sv
sim/testbench.sv
